// ===== hdl/blsq_pkg.sv =====
// shared types and constants for the banded least-squares line solver
// no dependencies; imported by blsq_regs, blsq_dp, blsq_ctrl and the core module
`default_nettype none

package blsq_pkg;

  // default sizes of the stores
  localparam int MAX_SOURCE_DEF = 4096;
  localparam int MAX_DEST_DEF   = 4096;
  localparam int MAX_TAPS_DEF   = 16;
  localparam int MAX_BAND_DEF   = 8;

  // port and datapath widths fixed by the item format
  localparam int DATA_W  = 32;
  localparam int POS_W   = 13;
  localparam int IDX_W   = 12;
  localparam int TAPP_W  = 4;
  localparam int FUNC_W  = 3;
  localparam int SPAN_W  = 14;
  localparam int ACC_W   = 72;
  localparam int PROD_W  = 104;
  localparam int PROD2_W = 64;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int BANDP_W = 4;

  // rounding shifts of the two finish modes
  localparam int SH_LONG  = 56;
  localparam int SH_SHORT = 28;

  // register reset values
  localparam int SRC_RESET  = 4096;
  localparam int DEST_RESET = 1;
  localparam int BAND_RESET = 5;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_DEST   = 2'd1;
  localparam logic [1:0] REG_BAND   = 2'd2;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic signed [DATA_W-1:0] ONE_Q28 = 32'sh1000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FN_SAMPLE, FN_WINDOW, FN_WEIGHT, FN_LOWER, FN_UPPER, FN_INVDIAG, FN_SOLVE, FN_READ
  } func_t;

  typedef enum logic [1:0] {TK_WS, TK_LO, TK_UP, TK_ID} term_kind_t;

  typedef struct packed {
    logic       load;
    logic       acc_clr;
    logic       win_rd;
    logic       term_v;
    term_kind_t term_kind;
    logic       sol_rd;
    logic       fin_start;
    logic       fin_long;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic fin_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/blsq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module blsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/blsq_regs.sv =====
// configuration registers behind the apb-style port
// depends on blsq_pkg
`default_nettype none

module blsq_regs #(
  parameter int MAX_SOURCE = blsq_pkg::MAX_SOURCE_DEF,
  parameter int MAX_DEST   = blsq_pkg::MAX_DEST_DEF,
  parameter int MAX_BAND   = blsq_pkg::MAX_BAND_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [blsq_pkg::CFG_AW-1:0]       paddr,
  input  wire logic [blsq_pkg::CFG_DW-1:0]       pwdata,
  output logic      [blsq_pkg::CFG_DW-1:0]       prdata,
  output logic                                   pready,
  output logic      [$clog2(MAX_SOURCE+1)-1:0]   source_count,
  output logic      [$clog2(MAX_DEST+1)-1:0]     dest_count,
  output logic      [$clog2(MAX_BAND+1)-1:0]     band
);
  import blsq_pkg::*;

  localparam int SRC_CW  = $clog2(MAX_SOURCE+1);
  localparam int DEST_CW = $clog2(MAX_DEST+1);
  localparam int BAND_CW = $clog2(MAX_BAND+1);

  logic [SRC_CW-1:0]  src_r;
  logic [DEST_CW-1:0] dest_r;
  logic [BAND_CW-1:0] band_r;
  logic [POS_W-1:0]   wv;
  logic [BANDP_W-1:0] bv;
  logic [1:0]         regsel;
  logic               wr;

  assign wv     = pwdata[POS_W-1:0];
  assign bv     = pwdata[BANDP_W-1:0];
  assign regsel = paddr[CFG_AW-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= SRC_CW'((SRC_RESET > MAX_SOURCE) ? MAX_SOURCE : SRC_RESET);
      dest_r <= DEST_CW'((DEST_RESET > MAX_DEST) ? MAX_DEST : DEST_RESET);
      band_r <= BAND_CW'((BAND_RESET > MAX_BAND) ? MAX_BAND : BAND_RESET);
    end else if (wr) begin
      case (regsel)
        REG_SOURCE: src_r  <= (32'(wv) > MAX_SOURCE) ? SRC_CW'(MAX_SOURCE) : SRC_CW'(wv);
        REG_DEST:   dest_r <= (32'(wv) > MAX_DEST) ? DEST_CW'(MAX_DEST) : DEST_CW'(wv);
        REG_BAND:   band_r <= (32'(bv) > MAX_BAND) ? BAND_CW'(MAX_BAND) : BAND_CW'(bv);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (regsel)
      REG_SOURCE: prdata = CFG_DW'(src_r);
      REG_DEST:   prdata = CFG_DW'(dest_r);
      REG_BAND:   prdata = CFG_DW'(band_r);
      default:    prdata = '0;
    endcase
  end

  assign source_count = src_r;
  assign dest_count   = dest_r;
  assign band         = band_r;

endmodule

`default_nettype wire

// ===== hdl/blsq_dp.sv =====
// datapath: table memories, multiply-accumulate pipeline, round and saturate unit
// depends on blsq_pkg and blsq_ram
`default_nettype none

module blsq_dp #(
  parameter int MAX_SOURCE = blsq_pkg::MAX_SOURCE_DEF,
  parameter int MAX_DEST   = blsq_pkg::MAX_DEST_DEF,
  parameter int MAX_TAPS   = blsq_pkg::MAX_TAPS_DEF,
  parameter int MAX_BAND   = blsq_pkg::MAX_BAND_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire blsq_pkg::dp_cmd_t                     cmd,
  output blsq_pkg::dp_stat_t                         stat,
  input  wire logic [blsq_pkg::FUNC_W-1:0]           in_func,
  input  wire logic [blsq_pkg::IDX_W-1:0]            in_index,
  input  wire logic [blsq_pkg::TAPP_W-1:0]           in_tap,
  input  wire logic signed [blsq_pkg::DATA_W-1:0]    in_data_value,
  input  wire logic [blsq_pkg::POS_W-1:0]            in_window_start,
  input  wire logic [blsq_pkg::POS_W-1:0]            in_window_end,
  input  wire logic [$clog2(MAX_DEST)-1:0]           row_addr,
  input  wire logic [$clog2(MAX_TAPS)-1:0]           tap_addr,
  input  wire logic [((MAX_BAND>1)?$clog2(MAX_BAND):1)-1:0] dist_addr,
  input  wire logic [$clog2(MAX_SOURCE)-1:0]         src_addr,
  input  wire logic [$clog2(MAX_DEST)-1:0]           sol_addr,
  output logic      [blsq_pkg::POS_W-1:0]            win_start,
  output logic      [blsq_pkg::POS_W-1:0]            win_end,
  output logic      [blsq_pkg::DATA_W-1:0]           sol_data
);
  import blsq_pkg::*;

  localparam int SRC_AW  = $clog2(MAX_SOURCE);
  localparam int DEST_AW = $clog2(MAX_DEST);
  localparam int TAP_W   = $clog2(MAX_TAPS);
  localparam int BAND_AW = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
  localparam int WIN_W   = 2 * POS_W;

  typedef enum logic [2:0] {
    FS_ABS, FS_MUL0, FS_MUL1, FS_MUL2, FS_ADD2, FS_HALF, FS_SAT
  } fin_step_t;

  func_t func;
  logic  dst_ok, src_ok, tap_ok, band_ok;

  logic [DATA_W-1:0] sample_q, weight_q, lower_q, upper_q, invd_q, sol_q;
  logic [WIN_W-1:0]  win_q;

  // multiply-accumulate pipeline
  logic                     v1_r, v2_r, sub2_r;
  term_kind_t               k1_r;
  logic signed [DATA_W-1:0] coef, opnd;
  logic signed [PROD2_W-1:0] p_nxt, p_r;
  logic signed [ACC_W-1:0]  acc_r;

  // finish unit
  logic                     fin_busy_r, fin_long_r, neg_r;
  fin_step_t                step_r;
  logic [DEST_AW-1:0]       fin_row_r;
  logic [ACC_W-1:0]         mag_r;
  logic [DATA_W-1:0]        mm_r, limb, lim_val, q, res;
  logic [PROD2_W-1:0]       pp_r;
  logic [PROD_W-1:0]        prod_r, half;
  logic signed [DATA_W-1:0] m;
  logic                     ovf, fin_we;

  assign func    = func_t'(in_func);
  assign dst_ok  = 32'(in_index) < MAX_DEST;
  assign src_ok  = 32'(in_index) < MAX_SOURCE;
  assign tap_ok  = 32'(in_tap) < MAX_TAPS;
  assign band_ok = 32'(in_tap) < MAX_BAND;

  blsq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SOURCE)) u_sample (
    .clk, .we(cmd.load && func == FN_SAMPLE && src_ok), .waddr(SRC_AW'(in_index)),
    .wdata(in_data_value), .re(cmd.term_v), .raddr(src_addr), .rdata(sample_q)
  );

  blsq_ram #(.WIDTH(WIN_W), .DEPTH(MAX_DEST)) u_window (
    .clk, .we(cmd.load && func == FN_WINDOW && dst_ok), .waddr(DEST_AW'(in_index)),
    .wdata({in_window_end, in_window_start}), .re(cmd.win_rd), .raddr(row_addr),
    .rdata(win_q)
  );

  blsq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEST << TAP_W)) u_weight (
    .clk, .we(cmd.load && func == FN_WEIGHT && dst_ok && tap_ok),
    .waddr({DEST_AW'(in_index), TAP_W'(in_tap)}), .wdata(in_data_value),
    .re(cmd.term_v), .raddr({row_addr, tap_addr}), .rdata(weight_q)
  );

  blsq_ram #(.WIDTH(DATA_W), .DEPTH(1 << (BAND_AW + DEST_AW))) u_lower (
    .clk, .we(cmd.load && func == FN_LOWER && dst_ok && band_ok),
    .waddr({BAND_AW'(in_tap), DEST_AW'(in_index)}), .wdata(in_data_value),
    .re(cmd.term_v), .raddr({dist_addr, row_addr}), .rdata(lower_q)
  );

  blsq_ram #(.WIDTH(DATA_W), .DEPTH(1 << (BAND_AW + DEST_AW))) u_upper (
    .clk, .we(cmd.load && func == FN_UPPER && dst_ok && band_ok),
    .waddr({BAND_AW'(in_tap), DEST_AW'(in_index)}), .wdata(in_data_value),
    .re(cmd.term_v), .raddr({dist_addr, row_addr}), .rdata(upper_q)
  );

  blsq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEST)) u_invdiag (
    .clk, .we(cmd.load && func == FN_INVDIAG && dst_ok), .waddr(DEST_AW'(in_index)),
    .wdata(in_data_value), .re(cmd.win_rd), .raddr(row_addr), .rdata(invd_q)
  );

  blsq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEST)) u_solution (
    .clk, .we(fin_we), .waddr(fin_row_r), .wdata(res),
    .re(cmd.term_v || cmd.sol_rd), .raddr(sol_addr), .rdata(sol_q)
  );

  assign win_start = win_q[POS_W-1:0];
  assign win_end   = win_q[WIN_W-1:POS_W];
  assign sol_data  = sol_q;

  always_comb begin
    case (k1_r)
      TK_WS:   begin coef = weight_q; opnd = sample_q; end
      TK_LO:   begin coef = lower_q;  opnd = sol_q;    end
      TK_UP:   begin coef = upper_q;  opnd = sol_q;    end
      TK_ID:   begin coef = ONE_Q28;  opnd = sol_q;    end
      default: begin coef = '0;       opnd = '0;       end
    endcase
    p_nxt = coef * opnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.term_v;
      v2_r <= v1_r;
    end
    k1_r   <= cmd.term_kind;
    p_r    <= p_nxt;
    sub2_r <= (k1_r == TK_LO) || (k1_r == TK_UP);
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= sub2_r ? acc_r - ACC_W'(p_r) : acc_r + ACC_W'(p_r);
    end
  end

  // finish: |acc| * |m| over three 32-bit limbs, then round half away and saturate
  assign m    = fin_long_r ? $signed(invd_q) : 32'sd1;
  assign half = fin_long_r ? (PROD_W'(1) << (SH_LONG - 1)) : (PROD_W'(1) << (SH_SHORT - 1));

  always_comb begin
    case (step_r)
      FS_MUL0: limb = mag_r[DATA_W-1:0];
      FS_MUL1: limb = mag_r[2*DATA_W-1:DATA_W];
      default: limb = DATA_W'(mag_r[ACC_W-1:2*DATA_W]);
    endcase
    if (fin_long_r) begin
      q   = prod_r[SH_LONG+DATA_W-1:SH_LONG];
      ovf = |prod_r[PROD_W-1:SH_LONG+DATA_W];
    end else begin
      q   = prod_r[SH_SHORT+DATA_W-1:SH_SHORT];
      ovf = |prod_r[PROD_W-1:SH_SHORT+DATA_W];
    end
    lim_val = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (ovf || q > lim_val) begin
      q = lim_val;
    end
    res = neg_r ? (~q + 32'd1) : q;
  end

  assign fin_we = fin_busy_r && step_r == FS_SAT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_busy_r <= 1'b0;
      step_r     <= FS_ABS;
    end else if (cmd.fin_start) begin
      fin_busy_r <= 1'b1;
      step_r     <= FS_ABS;
    end else if (fin_busy_r) begin
      case (step_r)
        FS_ABS:  step_r <= FS_MUL0;
        FS_MUL0: step_r <= FS_MUL1;
        FS_MUL1: step_r <= FS_MUL2;
        FS_MUL2: step_r <= FS_ADD2;
        FS_ADD2: step_r <= FS_HALF;
        FS_HALF: step_r <= FS_SAT;
        default: fin_busy_r <= 1'b0;
      endcase
    end
    if (cmd.fin_start) begin
      fin_long_r <= cmd.fin_long;
      fin_row_r  <= row_addr;
    end
    case (step_r)
      FS_ABS: begin
        mag_r  <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        neg_r  <= acc_r[ACC_W-1] ^ m[DATA_W-1];
        mm_r   <= m[DATA_W-1] ? DATA_W'(-m) : DATA_W'(m);
        prod_r <= '0;
      end
      FS_MUL0: pp_r <= mm_r * limb;
      FS_MUL1: begin
        pp_r   <= mm_r * limb;
        prod_r <= PROD_W'(pp_r);
      end
      FS_MUL2: begin
        pp_r   <= mm_r * limb;
        prod_r <= prod_r + (PROD_W'(pp_r) << DATA_W);
      end
      FS_ADD2: prod_r <= prod_r + (PROD_W'(pp_r) << (2 * DATA_W));
      FS_HALF: prod_r <= prod_r + half;
      default: ;
    endcase
  end

  assign stat.pipe_busy = v1_r || v2_r;
  assign stat.fin_done  = fin_we;

endmodule

`default_nettype wire

// ===== hdl/blsq_ctrl.sv =====
// controller: item handshake, row sequencing of forward and backward passes, result beat
// depends on blsq_pkg
`default_nettype none

module blsq_ctrl #(
  parameter int MAX_SOURCE = blsq_pkg::MAX_SOURCE_DEF,
  parameter int MAX_DEST   = blsq_pkg::MAX_DEST_DEF,
  parameter int MAX_TAPS   = blsq_pkg::MAX_TAPS_DEF,
  parameter int MAX_BAND   = blsq_pkg::MAX_BAND_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [blsq_pkg::FUNC_W-1:0]           in_func,
  input  wire logic [blsq_pkg::IDX_W-1:0]            in_index,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_kind,
  output logic      [blsq_pkg::IDX_W-1:0]            out_row,
  output logic signed [blsq_pkg::DATA_W-1:0]         out_result_value,
  input  wire logic [$clog2(MAX_SOURCE+1)-1:0]       source_count,
  input  wire logic [$clog2(MAX_DEST+1)-1:0]         dest_count,
  input  wire logic [$clog2(MAX_BAND+1)-1:0]         band,
  output blsq_pkg::dp_cmd_t                          cmd,
  input  wire blsq_pkg::dp_stat_t                    stat,
  input  wire logic [blsq_pkg::POS_W-1:0]            win_start,
  input  wire logic [blsq_pkg::POS_W-1:0]            win_end,
  input  wire logic [blsq_pkg::DATA_W-1:0]           sol_data,
  output logic      [$clog2(MAX_DEST)-1:0]           row_addr,
  output logic      [$clog2(MAX_TAPS)-1:0]           tap_addr,
  output logic      [((MAX_BAND>1)?$clog2(MAX_BAND):1)-1:0] dist_addr,
  output logic      [$clog2(MAX_SOURCE)-1:0]         src_addr,
  output logic      [$clog2(MAX_DEST)-1:0]           sol_addr
);
  import blsq_pkg::*;

  localparam int SRC_AW  = $clog2(MAX_SOURCE);
  localparam int DEST_AW = $clog2(MAX_DEST);
  localparam int TAP_W   = $clog2(MAX_TAPS);
  localparam int BAND_AW = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
  localparam int DEST_CW = $clog2(MAX_DEST+1);
  localparam int BAND_CW = $clog2(MAX_BAND+1);
  localparam int K_W     = $clog2(MAX_TAPS+1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_OUT, S_F_ROW, S_F_TAPS, S_F_LOW, S_F_DRAIN, S_F_FIN,
    S_B_ROW, S_B_UP, S_B_DRAIN, S_B_FIN, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [DEST_AW-1:0] i_r, i_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [BAND_CW-1:0] d_r, d_nxt, lim_r, lim_nxt;
  logic [DEST_CW-1:0] zero_from_r, zero_from_nxt, rem;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               out_valid_r, out_valid_nxt, out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]   out_row_r, out_row_nxt;
  logic [DATA_W-1:0]  out_val_r, out_val_nxt;
  logic [SPAN_W-1:0]  s;
  logic               slot_free;

  assign s         = SPAN_W'(win_start) + SPAN_W'(k_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign rem       = DEST_CW'(32'(dest_count) - 32'(i_r) - 1);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    d_nxt         = d_r;
    lim_nxt       = lim_r;
    zero_from_nxt = zero_from_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_row_nxt   = out_row_r;
    out_val_nxt   = out_val_r;
    cmd           = '0;
    row_addr      = i_r;
    tap_addr      = TAP_W'(k_r);
    dist_addr     = BAND_AW'(d_r - BAND_CW'(1));
    src_addr      = SRC_AW'(s);
    sol_addr      = i_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (func_t'(in_func))
            FN_SOLVE: begin
              zero_from_nxt = dest_count;
              i_nxt         = '0;
              state_nxt     = (dest_count == '0) ? S_DONE : S_F_ROW;
            end
            FN_READ: begin
              rd_idx_nxt = in_index;
              sol_addr   = DEST_AW'(in_index);
              cmd.sol_rd = 1'b1;
              state_nxt  = S_RD_OUT;
            end
            default: cmd.load = 1'b1;
          endcase
        end
      end
      S_RD_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_READ;
          out_row_nxt   = rd_idx_r;
          // rows past the last solve's count read as zero
          out_val_nxt   = (32'(rd_idx_r) < MAX_DEST && 32'(rd_idx_r) < 32'(zero_from_r))
                          ? sol_data : '0;
          state_nxt     = S_IDLE;
        end
      end
      S_F_ROW: begin
        cmd.win_rd  = 1'b1;
        cmd.acc_clr = 1'b1;
        k_nxt       = '0;
        state_nxt   = S_F_TAPS;
      end
      S_F_TAPS: begin
        if (32'(k_r) < MAX_TAPS && s < SPAN_W'(win_end)) begin
          k_nxt = k_r + K_W'(1);
          if (32'(s) < 32'(source_count) && 32'(s) < MAX_SOURCE) begin
            cmd.term_v    = 1'b1;
            cmd.term_kind = TK_WS;
          end
        end else begin
          lim_nxt   = (32'(band) < 32'(i_r)) ? band : BAND_CW'(i_r);
          d_nxt     = BAND_CW'(1);
          state_nxt = S_F_LOW;
        end
      end
      S_F_LOW: begin
        if (d_r <= lim_r) begin
          cmd.term_v    = 1'b1;
          cmd.term_kind = TK_LO;
          sol_addr      = DEST_AW'(32'(i_r) - 32'(d_r));
          d_nxt         = d_r + BAND_CW'(1);
        end else begin
          state_nxt = S_F_DRAIN;
        end
      end
      S_F_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.fin_start = 1'b1;
          cmd.fin_long  = 1'b1;
          state_nxt     = S_F_FIN;
        end
      end
      S_F_FIN: begin
        if (stat.fin_done) begin
          if (32'(i_r) + 1 < 32'(dest_count)) begin
            i_nxt     = i_r + DEST_AW'(1);
            state_nxt = S_F_ROW;
          end else begin
            state_nxt = S_B_ROW;
          end
        end
      end
      S_B_ROW: begin
        if (rem == '0) begin
          // last row keeps its forward value
          if (i_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt = i_r - DEST_AW'(1);
          end
        end else begin
          lim_nxt       = (32'(rem) > 32'(band)) ? band : BAND_CW'(rem);
          d_nxt         = BAND_CW'(1);
          cmd.acc_clr   = 1'b1;
          cmd.term_v    = 1'b1;
          cmd.term_kind = TK_ID;
          state_nxt     = S_B_UP;
        end
      end
      S_B_UP: begin
        if (d_r <= lim_r) begin
          cmd.term_v    = 1'b1;
          cmd.term_kind = TK_UP;
          sol_addr      = DEST_AW'(32'(i_r) + 32'(d_r));
          d_nxt         = d_r + BAND_CW'(1);
        end else begin
          state_nxt = S_B_DRAIN;
        end
      end
      S_B_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.fin_start = 1'b1;
          state_nxt     = S_B_FIN;
        end
      end
      S_B_FIN: begin
        if (stat.fin_done) begin
          if (i_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r - DEST_AW'(1);
            state_nxt = S_B_ROW;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DONE;
          out_row_nxt   = '0;
          out_val_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      zero_from_r <= DEST_CW'(MAX_DEST);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      zero_from_r <= zero_from_nxt;
    end
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    d_r        <= d_nxt;
    lim_r      <= lim_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_row_r  <= out_row_nxt;
    out_val_r  <= out_val_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_row          = out_row_r;
  assign out_result_value = out_val_r;

endmodule

`default_nettype wire

// ===== hdl/banded_least_squares_line_solver_core.sv =====
// loads: a table load is written as it is accepted, loads are accepted back to back;
// a read is registered onto the output beat once the output slot is free.
// solve: each forward row runs its window taps and min(band,row) lower terms, each backward
// row an identity term and min(band,rows left) upper terms, the last row no backward terms,
// via the one shared multiply-accumulate and seven-step round unit; the done beat then follows.
// reset: synchronous, clears control and loads register defaults; table memories keep contents
`default_nettype none

module banded_least_squares_line_solver_core #(
  parameter int MAX_SOURCE = blsq_pkg::MAX_SOURCE_DEF,
  parameter int MAX_DEST   = blsq_pkg::MAX_DEST_DEF,
  parameter int MAX_TAPS   = blsq_pkg::MAX_TAPS_DEF,
  parameter int MAX_BAND   = blsq_pkg::MAX_BAND_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [blsq_pkg::FUNC_W-1:0]        in_func,
  input  wire logic [blsq_pkg::IDX_W-1:0]         in_index,
  input  wire logic [blsq_pkg::TAPP_W-1:0]        in_tap,
  input  wire logic signed [blsq_pkg::DATA_W-1:0] in_data_value,
  input  wire logic [blsq_pkg::POS_W-1:0]         in_window_start,
  input  wire logic [blsq_pkg::POS_W-1:0]         in_window_end,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_kind,
  output logic      [blsq_pkg::IDX_W-1:0]         out_row,
  output logic signed [blsq_pkg::DATA_W-1:0]      out_result_value,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [blsq_pkg::CFG_AW-1:0]        paddr,
  input  wire logic [blsq_pkg::CFG_DW-1:0]        pwdata,
  output logic      [blsq_pkg::CFG_DW-1:0]        prdata,
  output logic                                    pready
);
  import blsq_pkg::*;

  localparam int SRC_AW  = $clog2(MAX_SOURCE);
  localparam int DEST_AW = $clog2(MAX_DEST);
  localparam int TAP_W   = $clog2(MAX_TAPS);
  localparam int BAND_AW = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;

  logic [$clog2(MAX_SOURCE+1)-1:0] source_count;
  logic [$clog2(MAX_DEST+1)-1:0]   dest_count;
  logic [$clog2(MAX_BAND+1)-1:0]   band;
  dp_cmd_t                         cmd;
  dp_stat_t                        stat;
  logic [POS_W-1:0]                win_start, win_end;
  logic [DATA_W-1:0]               sol_data;
  logic [DEST_AW-1:0]              row_addr, sol_addr;
  logic [TAP_W-1:0]                tap_addr;
  logic [BAND_AW-1:0]              dist_addr;
  logic [SRC_AW-1:0]               src_addr;

  blsq_regs #(.MAX_SOURCE(MAX_SOURCE), .MAX_DEST(MAX_DEST), .MAX_BAND(MAX_BAND)) u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .source_count, .dest_count, .band
  );

  blsq_ctrl #(
    .MAX_SOURCE(MAX_SOURCE), .MAX_DEST(MAX_DEST), .MAX_TAPS(MAX_TAPS), .MAX_BAND(MAX_BAND)
  ) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_index,
    .out_valid, .out_stall, .out_kind, .out_row, .out_result_value,
    .source_count, .dest_count, .band, .cmd, .stat, .win_start, .win_end, .sol_data,
    .row_addr, .tap_addr, .dist_addr, .src_addr, .sol_addr
  );

  blsq_dp #(
    .MAX_SOURCE(MAX_SOURCE), .MAX_DEST(MAX_DEST), .MAX_TAPS(MAX_TAPS), .MAX_BAND(MAX_BAND)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_func, .in_index, .in_tap, .in_data_value,
    .in_window_start, .in_window_end, .row_addr, .tap_addr, .dist_addr, .src_addr,
    .sol_addr, .win_start, .win_end, .sol_data
  );

  // the round unit starts only on a drained accumulator
  a_fin_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_start |-> !stat.pipe_busy)
    else $error("finish started with terms in flight");

  a_done_no_terms: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fin_done |-> !stat.pipe_busy)
    else $error("row stored while terms in flight");

  // table writes happen only on an accepted beat
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && !in_stall))
    else $error("table write without accepted beat");

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat raised from idle");

endmodule

`default_nettype wire
